### rtl/iee_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants of the Ising energy evaluator
// Item field widths, action codes, the fixed-point scale and the store
// write command passed from the top level to the graph store.
// ----------------------------------------------------------------------------
package iee_pkg;

	localparam int ACTION_W   = 2;
	localparam int VERTEX_W   = 4;
	localparam int ROW_W      = 16;
	localparam int FIELD_IN_W = 16;
	localparam int SPIN_W     = 16;
	localparam int ENERGY_W   = 24;
	localparam int Q_FRAC     = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE_ROW   = 2'd0,
		ACT_WRITE_FIELD = 2'd1,
		ACT_EVALUATE    = 2'd2
	} action_t;

	typedef struct packed {
		logic                  row_we;
		logic                  field_we;
		logic [VERTEX_W-1:0]   vertex;
		logic [ROW_W-1:0]      row;
		logic [FIELD_IN_W-1:0] field;
	} store_wr_t;

endpackage
`default_nettype wire

### rtl/iee_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iee_store: adjacency rows and local fields of the graph
// One register per vertex for each store, cleared at reset, all entries
// visible in parallel to the energy logic.
// ----------------------------------------------------------------------------
module iee_store
	import iee_pkg::*;
#(
	parameter int VERTICES   = 16,
	parameter int FIELD_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire store_wr_t             wr,
	output logic      [ROW_W-1:0]      rows   [VERTICES],
	output logic      [FIELD_BITS-1:0] fields [VERTICES]
);

	localparam int XW = (FIELD_BITS > FIELD_IN_W) ? FIELD_BITS : FIELD_IN_W;

	logic [ROW_W-1:0]      rows_q   [VERTICES];
	logic [FIELD_BITS-1:0] fields_q [VERTICES];
	logic [XW-1:0]         field_ext;

	assign field_ext = XW'($signed(wr.field));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VERTICES; k++) begin
				rows_q[k]   <= '0;
				fields_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < VERTICES; k++) begin
				if (wr.row_we && (32'(wr.vertex) == k)) begin
					rows_q[k] <= wr.row;
				end
				if (wr.field_we && (32'(wr.vertex) == k)) begin
					fields_q[k] <= field_ext[FIELD_BITS-1:0];
				end
			end
		end
	end

	assign rows   = rows_q;
	assign fields = fields_q;

endmodule
`default_nettype wire

### rtl/iee_energy.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iee_energy: diagonal energy of one spin configuration
// Per-vertex field and coupling terms summed through a binary adder tree,
// modulo 2^24 in signed Q16.8.
// ----------------------------------------------------------------------------
module iee_energy
	import iee_pkg::*;
#(
	parameter int VERTICES   = 16,
	parameter int FIELD_BITS = 16
) (
	input  wire logic [SPIN_W-1:0]     spin,
	input  wire logic [ROW_W-1:0]      rows   [VERTICES],
	input  wire logic [FIELD_BITS-1:0] fields [VERTICES],
	output logic      [ENERGY_W-1:0]   energy
);

	localparam int LEAVES = 1 << $clog2(VERTICES);
	localparam int XW     = (FIELD_BITS > ENERGY_W) ? FIELD_BITS : ENERGY_W;

	logic [ENERGY_W-1:0] node [1:2*LEAVES-1];

	for (genvar n = 0; n < LEAVES; n++) begin : g_leaf
		if (n < VERTICES) begin : g_term
			localparam logic [ROW_W-1:0] MASK = (n >= ROW_W) ? {ROW_W{1'b1}} :
				ROW_W'((64'd1 << n) - 64'd1);
			logic                sn;
			logic [ROW_W-1:0]    diff;
			logic [ROW_W-1:0]    agree;
			logic [ROW_W-1:0]    disagree;
			logic [XW-1:0]       fx;
			logic [ENERGY_W-1:0] fe;
			logic [ENERGY_W-1:0] edges;

			if (n < SPIN_W) begin : g_spin
				assign sn = spin[n];
			end else begin : g_down
				assign sn = 1'b0;
			end

			assign diff     = spin ^ {ROW_W{sn}};
			assign agree    = rows[n] & MASK & ~diff;
			assign disagree = rows[n] & MASK & diff;
			assign fx       = XW'($signed(fields[n]));
			assign fe       = fx[ENERGY_W-1:0];
			assign edges    = (ENERGY_W'($countones(agree))
				- ENERGY_W'($countones(disagree))) << Q_FRAC;
			assign node[LEAVES+n] = (sn ? fe : (ENERGY_W'(0) - fe)) + edges;
		end else begin : g_pad
			assign node[LEAVES+n] = '0;
		end
	end

	for (genvar i = 1; i < LEAVES; i++) begin : g_tree
		assign node[i] = node[2*i] + node[2*i+1];
	end

	assign energy = node[1];

endmodule
`default_nettype wire

### rtl/ising_energy_evaluator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ising_energy_evaluator_core: Ising energy of spin configurations on a graph
// Top level: command register, graph store, energy tree and result register.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless the command side stalls. Write
// items load a vertex's adjacency row or local field and give no result; an
// evaluate item gives its energy through one register holding the
// configuration and one holding the result, with the combinational adder tree
// over all vertices between them. A result waiting at the output does not
// block the next item; only a second finished result stalls the command side.
// ----------------------------------------------------------------------------
module ising_energy_evaluator_core
	import iee_pkg::*;
#(
	parameter int VERTICES   = 16,
	parameter int FIELD_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire logic [ACTION_W-1:0]   action,
	input  wire logic [VERTEX_W-1:0]   vertex,
	input  wire logic [ROW_W-1:0]      adjacency_row,
	input  wire logic [FIELD_IN_W-1:0] field_value,
	input  wire logic [SPIN_W-1:0]     spin_state,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output logic      [ENERGY_W-1:0]   energy
);

	logic                  fire;
	logic                  advance;
	logic                  eval_valid_s1;
	logic [SPIN_W-1:0]     spin_s1;
	logic                  result_valid_q;
	logic [ENERGY_W-1:0]   energy_q;
	logic [ENERGY_W-1:0]   energy_sum;
	store_wr_t             wr;
	logic [ROW_W-1:0]      rows   [VERTICES];
	logic [FIELD_BITS-1:0] fields [VERTICES];

	assign advance   = eval_valid_s1 && (!result_valid_q || result_ready);
	assign cmd_ready = !eval_valid_s1 || !result_valid_q || result_ready;
	assign fire      = cmd_valid && cmd_ready;

	always_comb begin
		wr.row_we   = 1'b0;
		wr.field_we = 1'b0;
		wr.vertex   = vertex;
		wr.row      = adjacency_row;
		wr.field    = field_value;
		unique case (action_t'(action))
			ACT_WRITE_ROW:   wr.row_we   = fire;
			ACT_WRITE_FIELD: wr.field_we = fire;
			ACT_EVALUATE:    ;
			default:         ;
		endcase
	end

	iee_store #(
		.VERTICES   (VERTICES),
		.FIELD_BITS (FIELD_BITS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rows   (rows),
		.fields (fields)
	);

	iee_energy #(
		.VERTICES   (VERTICES),
		.FIELD_BITS (FIELD_BITS)
	) u_energy (
		.spin   (spin_s1),
		.rows   (rows),
		.fields (fields),
		.energy (energy_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_valid_s1 <= 1'b0;
		end else if (fire && (action_t'(action) == ACT_EVALUATE)) begin
			eval_valid_s1 <= 1'b1;
		end else if (advance) begin
			eval_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			spin_s1 <= spin_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			energy_q <= energy_sum;
		end
	end

	assign result_valid = result_valid_q;
	assign energy       = energy_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> (eval_valid_s1 && result_valid_q && !result_ready))
		else $error("command side stalled without a blocked result");

	a_eval_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (action == ACT_EVALUATE)) |=> eval_valid_s1)
		else $error("accepted evaluate item not held in stage 1");

	a_write_no_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (action != ACT_EVALUATE)) |=> !eval_valid_s1)
		else $error("write item left an evaluation pending");

	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (result_valid_q && (energy_q == $past(energy_sum))))
		else $error("evaluated energy not presented as a result");

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ising_energy_evaluator_core
// Drives write, evaluate and unused items through the command channel, keeps a
// local copy of the adjacency rows and fields, computes the energy of every
// evaluate item and checks each result item in order. Random idling on both
// channels, a long receiver hold-off, a drain pause and a closing burst with
// no idling.
// ----------------------------------------------------------------------------
module testbench
	import iee_pkg::*;
();

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int Q_ONE       = 1 << Q_FRAC;
	localparam int NUM_VERTEX  = 16;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  cmd_valid;
	logic                  cmd_ready;
	logic [ACTION_W-1:0]   action;
	logic [VERTEX_W-1:0]   vertex;
	logic [ROW_W-1:0]      adjacency_row;
	logic [FIELD_IN_W-1:0] field_value;
	logic [SPIN_W-1:0]     spin_state;
	logic                  result_valid;
	logic                  result_ready;
	logic [ENERGY_W-1:0]   energy;

	logic        [ROW_W-1:0]      graph_rows    [NUM_VERTEX];
	logic signed [FIELD_IN_W-1:0] vertex_fields [NUM_VERTEX];
	logic        [ENERGY_W-1:0]   energy_due    [$];

	int mismatches = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	int rx_hold_request = 0;
	bit tx_idle_on = 1;
	bit rx_idle_on = 1;

	ising_energy_evaluator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.action        (action),
		.vertex        (vertex),
		.adjacency_row (adjacency_row),
		.field_value   (field_value),
		.spin_state    (spin_state),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.energy        (energy)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [ENERGY_W-1:0] ising_energy(input logic [SPIN_W-1:0] spins);
		int total;
		total = 0;
		for (int n = 0; n < NUM_VERTEX; n++) begin
			if (spins[n])
				total += int'(vertex_fields[n]);
			else
				total -= int'(vertex_fields[n]);
			for (int m = 0; m < n; m++) begin
				if (graph_rows[n][m])
					total += (spins[n] == spins[m]) ? Q_ONE : -Q_ONE;
			end
		end
		return total[ENERGY_W-1:0];
	endfunction

	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VERTEX_W-1:0] vx,
			input logic [ROW_W-1:0] row, input logic [FIELD_IN_W-1:0] fld,
			input logic [SPIN_W-1:0] spins);
		cmd_valid     <= 1'b1;
		action        <= act;
		vertex        <= vx;
		adjacency_row <= row;
		field_value   <= fld;
		spin_state    <= spins;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		items_sent++;
		case (act)
			ACT_WRITE_ROW:   graph_rows[vx] = row;
			ACT_WRITE_FIELD: vertex_fields[vx] = fld;
			ACT_EVALUATE:    energy_due.push_back(ising_energy(spins));
			default: ;
		endcase
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic send_random_item();
		int pick;
		logic [ACTION_W-1:0] act;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			act = ACT_WRITE_ROW;
		else if (pick < 30)
			act = ACT_WRITE_FIELD;
		else if (pick < 95)
			act = ACT_EVALUATE;
		else
			act = ACT_UNUSED;
		send_item(act, VERTEX_W'($urandom_range(0, 15)), ROW_W'($urandom_range(0, 65535)),
			FIELD_IN_W'($urandom_range(0, 65535)), SPIN_W'($urandom_range(0, 65535)));
	endtask

	task automatic pause_until_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (energy_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_reset_state();
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'h0000);
		send_item(ACT_EVALUATE, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_directed_extremes();
		send_item(ACT_WRITE_FIELD, 4'd0, 16'h0000, 16'h8000, 16'h0000);
		send_item(ACT_WRITE_FIELD, 4'd15, 16'hFFFF, 16'h7FFF, 16'hFFFF);
		send_item(ACT_WRITE_FIELD, 4'd7, 16'h0000, 16'hFFFF, 16'h0000);
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'h8001);
		send_item(ACT_WRITE_ROW, 4'd15, 16'hFFFF, 16'h0000, 16'h0000);
		send_item(ACT_WRITE_ROW, 4'd0, 16'hFFFF, 16'h0000, 16'h0000);
		send_item(ACT_WRITE_ROW, 4'd5, 16'hFFE0, 16'h0000, 16'h0000);
		send_item(ACT_WRITE_ROW, 4'd9, 16'h01FF, 16'h0000, 16'h0000);
		send_item(ACT_UNUSED, 4'd3, 16'hFFFF, 16'h7FFF, 16'hFFFF);
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'h0000);
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'hFFFF);
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'hAAAA);
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'h5555);
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'h8000);
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'h0001);
		send_item(ACT_UNUSED, 4'd15, 16'h0000, 16'h8000, 16'h0000);
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'h0200);
		send_item(ACT_WRITE_FIELD, 4'd15, 16'h0000, 16'h0000, 16'h0000);
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'hFFFF);
		send_item(ACT_WRITE_ROW, 4'd15, 16'h0000, 16'h0000, 16'h0000);
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'h7FFF);
	endtask

	// reload the whole graph, then evaluate a burst of configurations
	task automatic reload_and_evaluate();
		int style;
		logic [FIELD_IN_W-1:0] fld;
		logic [ROW_W-1:0] row;
		style = $urandom_range(0, 3);
		for (int v = 0; v < NUM_VERTEX; v++) begin
			case (style)
				0: fld = 16'h8000;
				1: fld = 16'h7FFF;
				default: fld = FIELD_IN_W'($urandom_range(0, 65535));
			endcase
			send_item(ACT_WRITE_FIELD, VERTEX_W'(v), ROW_W'($urandom_range(0, 65535)), fld,
				SPIN_W'($urandom_range(0, 65535)));
		end
		for (int v = 0; v < NUM_VERTEX; v++) begin
			row = (style < 2) ? 16'hFFFF : ROW_W'($urandom_range(0, 65535));
			send_item(ACT_WRITE_ROW, VERTEX_W'(v), row, FIELD_IN_W'($urandom_range(0, 65535)),
				SPIN_W'($urandom_range(0, 65535)));
		end
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'h0000);
		send_item(ACT_EVALUATE, 4'd0, 16'h0000, 16'h0000, 16'hFFFF);
		repeat ($urandom_range(4, 16))
			send_item(ACT_EVALUATE, VERTEX_W'($urandom_range(0, 15)),
				ROW_W'($urandom_range(0, 65535)), FIELD_IN_W'($urandom_range(0, 65535)),
				SPIN_W'($urandom_range(0, 65535)));
	endtask

	task automatic test_random_traffic(input int target);
		int start;
		int next_switch;
		start = items_sent;
		next_switch = items_sent + 100;
		while (items_sent - start < target) begin
			if (items_sent >= next_switch) begin
				tx_idle_on = ($urandom_range(0, 2) != 0);
				rx_idle_on = ($urandom_range(0, 2) != 0);
				next_switch = items_sent + 100;
			end
			if ($urandom_range(0, 29) == 0)
				reload_and_evaluate();
			else
				send_random_item();
		end
		tx_idle_on = 1;
		rx_idle_on = 1;
	endtask

	task automatic test_receiver_hold();
		tx_idle_on = 0;
		rx_hold_request = HOLD_CYCLES;
		repeat (40)
			send_item(ACT_EVALUATE, VERTEX_W'($urandom_range(0, 15)),
				ROW_W'($urandom_range(0, 65535)), FIELD_IN_W'($urandom_range(0, 65535)),
				SPIN_W'($urandom_range(0, 65535)));
		tx_idle_on = 1;
		pause_until_drained();
	endtask

	task automatic test_streaming();
		tx_idle_on = 0;
		rx_idle_on = 0;
		repeat (120) send_random_item();
	endtask

	always begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_request > 0) begin
				hold_left = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				result_ready <= 1'b0;
				stall_left = $urandom_range(1, 8) - 1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (energy_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("testbench: unexpected result item, energy %h", energy);
			end else begin
				if (energy !== energy_due[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("testbench: energy mismatch, expected %h, got %h",
							energy_due[0], energy);
				end
				void'(energy_due.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cmd_valid     <= 1'b0;
		action        <= ACT_WRITE_ROW;
		vertex        <= '0;
		adjacency_row <= '0;
		field_value   <= '0;
		spin_state    <= '0;
		for (int v = 0; v < NUM_VERTEX; v++) begin
			graph_rows[v]    = '0;
			vertex_fields[v] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_extremes();
		pause_until_drained();
		test_random_traffic(850);
		test_receiver_hold();
		test_streaming();

		cmd_valid <= 1'b0;
		while (energy_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
